[hw/rtl/strongly_connected_members_macros.svh]
// assertion macros for the strongly connected members block
// used by the top level only, needs clk and rst_n in scope
`ifndef STRONGLY_CONNECTED_MEMBERS_MACROS_SVH
`define STRONGLY_CONNECTED_MEMBERS_MACROS_SVH

// same-cycle implication, checked out of reset
`define SCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/scc_pkg.sv]
// shared types, codes and helpers for the strongly connected members block
// no dependencies
package scc_pkg;

  localparam int NODE_W      = 5;   // node index field width
  localparam int CFG_W       = 6;   // node count register width
  localparam int MASK_W      = 32;  // member mask width
  localparam int COUNT_W     = 5;   // member count width
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int CHUNK_W     = 8;   // bits counted per cycle
  localparam int CHUNKS      = MASK_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(CHUNKS);
  localparam int ACC_W       = COUNT_W + 1;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(32);

  typedef enum logic {
    CMD_EDGE  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_SWEEP,
    ST_COUNT,
    ST_DONE
  } state_t;

  function automatic logic [3:0] popcount8(input logic [CHUNK_W-1:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < CHUNK_W; k++) begin
      c = c + 4'(v[k]);
    end
    return c;
  endfunction

endpackage

[hw/rtl/scc_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/scc_row_unit.sv]
// shared row unit: folds one adjacency row into both reach sets
// depends on nothing but its parameter
module scc_row_unit #(
  parameter int MAX_NODES = 32
) (
  input  logic [MAX_NODES-1:0]         row,
  input  logic [$clog2(MAX_NODES)-1:0] row_idx,
  input  logic [MAX_NODES-1:0]         act,
  input  logic [MAX_NODES-1:0]         fwd_seen,
  input  logic [MAX_NODES-1:0]         bwd_seen,
  output logic [MAX_NODES-1:0]         fwd_seen_nxt,
  output logic [MAX_NODES-1:0]         bwd_seen_nxt,
  output logic                         changed
);

  logic [MAX_NODES-1:0] fwd_add;
  logic                 bwd_hit;

  always_comb begin
    // forward: a reached tail adds its active heads
    fwd_add      = fwd_seen[row_idx] ? (row & act) : '0;
    fwd_seen_nxt = fwd_seen | fwd_add;
    // backward: a tail pointing into the set joins it
    bwd_hit      = |(row & bwd_seen);
    bwd_seen_nxt = bwd_seen | (bwd_hit ? (MAX_NODES'(1) << row_idx) : '0);
    changed      = (fwd_seen_nxt != fwd_seen) || (bwd_seen_nxt != bwd_seen);
  end

endmodule

[hw/rtl/strongly_connected_members.sv]
// Strongly connected members of one node. The block holds a directed adjacency bit
// matrix in a ram of MAX_NODES rows (bit j of row i is edge i -> j). An edge word
// (tuser 0) sets or clears one edge and gives no result; it reads the row and then
// writes it back, but when an endpoint is not below the active node count it is
// dropped. A query word (tuser 1) names a source; the block sweeps the rows of the
// active nodes, one row a cycle through one shared row unit, growing the forward
// and backward reach sets together, and repeats whole sweeps until a sweep adds
// nothing. The number of sweeps is one more than the longest chain of new
// discoveries, at most about n+1 for n active nodes. The member mask is then
// counted eight bits a cycle. A source at or beyond the node count skips the
// sweeps and returns source_error. The block takes one word at a time; a
// finished result sits in the output register so the next word can be taken
// while it waits. Rows read as zero until first written, so there is no
// clearing pass after reset. node_count may only be written while idle.
// depends on scc_pkg, scc_ram, scc_row_unit and the assertion macro header
`include "strongly_connected_members_macros.svh"

module strongly_connected_members
  import scc_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,   // node_count
  // input words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // from_node[4:0], to_node[9:5], edge_present[10]
  input  logic                   in_tuser,      // cmd
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,     // member_mask[31:0], member_count[36:32]
  output logic                   out_tuser      // source_error
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int EXT_W = (MAX_NODES > MASK_W) ? MAX_NODES : MASK_W;

  // input fields
  logic [NODE_W-1:0] in_from;
  logic [NODE_W-1:0] in_to;
  logic              in_present;
  assign in_from    = in_tdata[NODE_W-1:0];
  assign in_to      = in_tdata[2*NODE_W-1:NODE_W];
  assign in_present = in_tdata[2*NODE_W];

  // control and working state
  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       node_count_r;
  logic [MAX_NODES-1:0]   row_valid_r, row_valid_nxt;
  logic [NODE_W-1:0]      from_r, from_nxt;
  logic [NODE_W-1:0]      to_r, to_nxt;
  logic                   present_r, present_nxt;
  logic [MAX_NODES-1:0]   fwd_seen_r, fwd_seen_nxt;
  logic [MAX_NODES-1:0]   bwd_seen_r, bwd_seen_nxt;
  logic [CNT_W-1:0]       issue_r, issue_nxt;
  logic                   pend_r, pend_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic                   rd_ok_r, rd_ok_nxt;
  logic                   changed_r, changed_nxt;
  logic [CHUNK_IDX_W-1:0] chunk_r, chunk_nxt;
  logic [MASK_W-1:0]      res_mask_r, res_mask_nxt;
  logic [ACC_W-1:0]       res_cnt_r, res_cnt_nxt;
  logic                   res_err_r, res_err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]      out_mask_r, out_mask_nxt;
  logic [COUNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                   out_err_r, out_err_nxt;

  // active node count and mask
  logic [CNT_W-1:0]     n_act;
  logic [MAX_NODES-1:0] act;

  always_comb begin
    n_act = (int'(node_count_r) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count_r);
    for (int k = 0; k < MAX_NODES; k++) begin
      act[k] = (k < int'(n_act));
    end
  end

  // adjacency ram
  logic                 ram_wr_en;
  logic [IDX_W-1:0]     ram_wr_addr;
  logic [MAX_NODES-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [IDX_W-1:0]     ram_rd_addr;
  logic [MAX_NODES-1:0] ram_rd_data;
  logic [MAX_NODES-1:0] row_q;

  scc_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // a row never written reads as no edges
  assign row_q = rd_ok_r ? ram_rd_data : '0;

  // shared row unit
  logic [MAX_NODES-1:0] unit_fwd;
  logic [MAX_NODES-1:0] unit_bwd;
  logic                 unit_changed;

  scc_row_unit #(
    .MAX_NODES (MAX_NODES)
  ) u_row_unit (
    .row          (row_q),
    .row_idx      (pend_idx_r),
    .act          (act),
    .fwd_seen     (fwd_seen_r),
    .bwd_seen     (bwd_seen_r),
    .fwd_seen_nxt (unit_fwd),
    .bwd_seen_nxt (unit_bwd),
    .changed      (unit_changed)
  );

  // members: both sets, active only, source excluded, fitted to 32 bits
  logic [MAX_NODES-1:0] both;
  logic [EXT_W-1:0]     both_ext;
  logic [MASK_W-1:0]    members;

  always_comb begin
    both     = fwd_seen_r & bwd_seen_r & act;
    both_ext = EXT_W'(both);
    members  = both_ext[MASK_W-1:0] & ~(MASK_W'(1) << from_r);
  end

  assign in_tready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    row_valid_nxt = row_valid_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    present_nxt   = present_r;
    fwd_seen_nxt  = fwd_seen_r;
    bwd_seen_nxt  = bwd_seen_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    rd_ok_nxt     = rd_ok_r;
    changed_nxt   = changed_r;
    chunk_nxt     = chunk_r;
    res_mask_nxt  = res_mask_r;
    res_cnt_nxt   = res_cnt_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_mask_nxt  = out_mask_r;
    out_cnt_nxt   = out_cnt_r;
    out_err_nxt   = out_err_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = IDX_W'(from_r);
    ram_wr_data   = '0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = IDX_W'(from_r);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          from_nxt    = in_from;
          to_nxt      = in_to;
          present_nxt = in_present;
          if (cmd_t'(in_tuser) == CMD_EDGE) begin
            // endpoints outside the active range drop the word
            if ((int'(in_from) < int'(n_act)) && (int'(in_to) < int'(n_act))) begin
              state_nxt = ST_EDGE_RD;
            end
          end else if (int'(in_from) < int'(n_act)) begin
            fwd_seen_nxt = MAX_NODES'(1) << in_from;
            bwd_seen_nxt = MAX_NODES'(1) << in_from;
            issue_nxt    = '0;
            changed_nxt  = 1'b0;
            state_nxt    = ST_SWEEP;
          end else begin
            fwd_seen_nxt = '0;
            bwd_seen_nxt = '0;
            res_mask_nxt = '0;
            res_cnt_nxt  = '0;
            res_err_nxt  = 1'b1;
            state_nxt    = ST_DONE;
          end
        end
      end

      ST_EDGE_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = IDX_W'(from_r);
        rd_ok_nxt   = row_valid_r[IDX_W'(from_r)];
        state_nxt   = ST_EDGE_WR;
      end

      ST_EDGE_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = IDX_W'(from_r);
        ram_wr_data = present_r ? (row_q | (MAX_NODES'(1) << to_r))
                                : (row_q & ~(MAX_NODES'(1) << to_r));
        row_valid_nxt[IDX_W'(from_r)] = 1'b1;
        state_nxt   = ST_IDLE;
      end

      ST_SWEEP: begin
        // fold the row read last cycle
        if (pend_r) begin
          fwd_seen_nxt = unit_fwd;
          bwd_seen_nxt = unit_bwd;
          changed_nxt  = changed_r | unit_changed;
        end
        // issue the next row of this sweep
        if (issue_r < n_act) begin
          ram_rd_en    = 1'b1;
          ram_rd_addr  = issue_r[IDX_W-1:0];
          rd_ok_nxt    = row_valid_r[issue_r[IDX_W-1:0]];
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt    = issue_r + CNT_W'(1);
        end else if (!pend_r) begin
          if (changed_r) begin
            issue_nxt   = '0;
            changed_nxt = 1'b0;
          end else begin
            res_mask_nxt = members;
            res_cnt_nxt  = '0;
            res_err_nxt  = 1'b0;
            chunk_nxt    = '0;
            state_nxt    = ST_COUNT;
          end
        end
      end

      ST_COUNT: begin
        res_cnt_nxt = res_cnt_r
                    + ACC_W'(popcount8(res_mask_r[{chunk_r, 3'b000} +: CHUNK_W]));
        chunk_nxt   = chunk_r + CHUNK_IDX_W'(1);
        if (chunk_r == CHUNK_IDX_W'(CHUNKS - 1)) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = res_mask_r;
          out_cnt_nxt   = res_cnt_r[COUNT_W-1:0];
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_valid_r  <= '0;
      node_count_r <= NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_valid_r  <= row_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= pend_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    present_r  <= present_nxt;
    fwd_seen_r <= fwd_seen_nxt;
    bwd_seen_r <= bwd_seen_nxt;
    issue_r    <= issue_nxt;
    pend_idx_r <= pend_idx_nxt;
    rd_ok_r    <= rd_ok_nxt;
    changed_r  <= changed_nxt;
    chunk_r    <= chunk_nxt;
    res_mask_r <= res_mask_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_err_r  <= res_err_nxt;
    out_mask_r <= out_mask_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - MASK_W - COUNT_W)'(0), out_cnt_r, out_mask_r};
  assign out_tuser  = out_err_r;

  // checks
  `SCC_ASSERT_SAME(a_err_empty, out_valid_r && out_err_r,
                   (out_mask_r == '0) && (out_cnt_r == '0),
                   "error result carries members")
  `SCC_ASSERT_SAME(a_count_matches, out_valid_r,
                   $countones(out_mask_r) == int'(out_cnt_r),
                   "member count disagrees with mask")
  `SCC_ASSERT_NEXT(a_query_busy, in_tvalid && in_tready && (cmd_t'(in_tuser) == CMD_QUERY),
                   !in_tready, "query taken but block still ready")
  `SCC_ASSERT_SAME(a_sweep_active, state_r == ST_SWEEP && pend_r,
                   int'(pend_idx_r) < int'(n_act), "sweep row outside active range")

endmodule
